// File: hw/rtl/dvu_pkg.sv
// Shared types for the direction unit vector block.
// Depends on nothing; imported by every cell and by the top level.
package dvu_pkg;

	typedef struct packed {
		logic en;
		logic vld;
	} dvu_ctl_t;

	localparam int unsigned NUM_AXES = 3;

endpackage

// File: hw/rtl/dvu_sqrt_cell.sv
// One digit cell of the square root chain: settles one root bit per cycle while ctl_i.en is high.
// Depends on dvu_pkg for the control struct.
module dvu_sqrt_cell #(
	parameter int unsigned RB = 26,
	parameter int unsigned PW = 78
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  dvu_pkg::dvu_ctl_t      ctl_i,
	input  logic [2*RB-1:0]        rad_i,
	input  logic [RB+1:0]          rem_i,
	input  logic [RB-1:0]          root_i,
	input  logic [PW-1:0]          pl_i,
	output logic                   vld_o,
	output logic [2*RB-1:0]        rad_o,
	output logic [RB+1:0]          rem_o,
	output logic [RB-1:0]          root_o,
	output logic [PW-1:0]          pl_o
);
	import dvu_pkg::*;

	logic [RB+3:0] rem_sh;
	logic [RB+3:0] trial;
	logic          take;

	always_comb begin
		rem_sh = {rem_i, rad_i[2*RB-1 -: 2]};
		trial  = {2'b00, root_i, 2'b01};
		take   = rem_sh >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (ctl_i.en) begin
			vld_o <= ctl_i.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_i.en) begin
			rad_o  <= {rad_i[2*RB-3:0], 2'b00};
			rem_o  <= take ? (RB+2)'(rem_sh - trial) : rem_sh[RB+1:0];
			root_o <= {root_i[RB-2:0], take};
			pl_o   <= pl_i;
		end
	end

endmodule

// File: hw/rtl/dvu_div_cell.sv
// One quotient cell of the divider chain: one quotient bit per axis per cycle while ctl_i.en is high.
// Depends on dvu_pkg for the control struct and the axis count.
module dvu_div_cell #(
	parameter int unsigned DW    = 25,
	parameter int unsigned QW    = 17,
	parameter bit          FIRST = 1'b0
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dvu_pkg::dvu_ctl_t       ctl_i,
	input  logic [DW-1:0]           dist_i,
	input  logic [2:0][DW-1:0]      r_i,
	input  logic [2:0][QW-1:0]      q_i,
	input  logic [2:0]              sgn_i,
	output logic                    vld_o,
	output logic [DW-1:0]           dist_o,
	output logic [2:0][DW-1:0]      r_o,
	output logic [2:0][QW-1:0]      q_o,
	output logic [2:0]              sgn_o
);
	import dvu_pkg::*;

	logic [NUM_AXES-1:0][DW:0] rs;
	logic [NUM_AXES-1:0]       take;

	always_comb begin
		for (int k = 0; k < NUM_AXES; k++) begin
			rs[k]   = FIRST ? {1'b0, r_i[k]} : {r_i[k], 1'b0};
			take[k] = rs[k] >= {1'b0, dist_i};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (ctl_i.en) begin
			vld_o <= ctl_i.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_i.en) begin
			dist_o <= dist_i;
			sgn_o  <= sgn_i;
			for (int k = 0; k < NUM_AXES; k++) begin
				r_o[k] <= take[k] ? DW'(rs[k] - {1'b0, dist_i}) : rs[k][DW-1:0];
				q_o[k] <= {q_i[k][QW-2:0], take[k]};
			end
		end
	end

endmodule

// File: hw/rtl/direction_unit_vector.sv
// Top level of the direction unit vector block: differences, squares, root and divider chains.
// Depends on dvu_pkg, dvu_sqrt_cell and dvu_div_cell.
//
// channel | valid     | ready     | payload
// input   | in_valid  | in_ready  | start_x..z, end_x..z
// output  | out_valid | out_ready | unit_x..z, span_length, zero_length
//
// One transfer per cycle is sustained while out_ready stays high.
// The pipeline is made of three front stages, one root cell per root bit and one
// divider cell per quotient bit.
// All stages advance together; when a result waits on out_ready the whole chain holds.
// Reset clears only the valid bits of the stages.
module direction_unit_vector #(
	parameter int unsigned COORD_BITS     = 24,
	parameter int unsigned UNIT_FRAC_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [COORD_BITS-1:0]       start_x,
	input  logic signed [COORD_BITS-1:0]       start_y,
	input  logic signed [COORD_BITS-1:0]       start_z,
	input  logic signed [COORD_BITS-1:0]       end_x,
	input  logic signed [COORD_BITS-1:0]       end_y,
	input  logic signed [COORD_BITS-1:0]       end_z,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [UNIT_FRAC_BITS+1:0]   unit_x,
	output logic signed [UNIT_FRAC_BITS+1:0]   unit_y,
	output logic signed [UNIT_FRAC_BITS+1:0]   unit_z,
	output logic [COORD_BITS:0]                span_length,
	output logic                               zero_length
);
	import dvu_pkg::*;

	localparam int unsigned MW = COORD_BITS + 1;
	localparam int unsigned RB = COORD_BITS + 2;
	localparam int unsigned SW = 2 * RB;
	localparam int unsigned QW = UNIT_FRAC_BITS + 1;
	localparam int unsigned UW = UNIT_FRAC_BITS + 2;
	localparam int unsigned PW = NUM_AXES * MW + NUM_AXES;

	logic en;
	logic vld_s1, vld_s2, vld_s3;
	logic [NUM_AXES-1:0][MW-1:0]   mag_s1, mag_s2;
	logic [NUM_AXES-1:0]           sgn_s1, sgn_s2;
	logic [NUM_AXES-1:0][2*MW-1:0] sq_s2;
	logic [SW-1:0]                 sum_s3;
	logic [PW-1:0]                 pl_s3;
	logic [NUM_AXES-1:0][MW:0]     dif;
	logic [NUM_AXES-1:0][COORD_BITS-1:0] st_c, en_c;

	assign st_c = {start_z, start_y, start_x};
	assign en_c = {end_z, end_y, end_x};

	always_comb begin
		for (int k = 0; k < NUM_AXES; k++) begin
			dif[k] = {en_c[k][COORD_BITS-1], en_c[k][COORD_BITS-1], en_c[k]}
				- {st_c[k][COORD_BITS-1], st_c[k][COORD_BITS-1], st_c[k]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NUM_AXES; k++) begin
				sgn_s1[k] <= dif[k][MW];
				mag_s1[k] <= dif[k][MW] ? MW'(-dif[k]) : dif[k][MW-1:0];
				sq_s2[k]  <= mag_s1[k] * mag_s1[k];
			end
			mag_s2 <= mag_s1;
			sgn_s2 <= sgn_s1;
			sum_s3 <= SW'(sq_s2[0]) + SW'(sq_s2[1]) + SW'(sq_s2[2]);
			pl_s3  <= {sgn_s2, mag_s2};
		end
	end

	logic [RB:0]                 sv;
	logic [RB:0][SW-1:0]         rad_c;
	logic [RB:0][RB+1:0]         rem_c;
	logic [RB:0][RB-1:0]         root_c;
	logic [RB:0][PW-1:0]         pl_c;

	assign sv[0]     = vld_s3;
	assign rad_c[0]  = sum_s3;
	assign rem_c[0]  = '0;
	assign root_c[0] = '0;
	assign pl_c[0]   = pl_s3;

	for (genvar i = 0; i < RB; i++) begin : g_sqrt
		dvu_sqrt_cell #(.RB(RB), .PW(PW)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl_i  ('{en: en, vld: sv[i]}),
			.rad_i  (rad_c[i]),
			.rem_i  (rem_c[i]),
			.root_i (root_c[i]),
			.pl_i   (pl_c[i]),
			.vld_o  (sv[i+1]),
			.rad_o  (rad_c[i+1]),
			.rem_o  (rem_c[i+1]),
			.root_o (root_c[i+1]),
			.pl_o   (pl_c[i+1])
		);
	end

	logic [QW:0]                     dv;
	logic [QW:0][MW-1:0]             dist_c;
	logic [QW:0][2:0][MW-1:0]        r_c;
	logic [QW:0][2:0][QW-1:0]        q_c;
	logic [QW:0][2:0]                sg_c;

	assign dv[0]     = sv[RB];
	assign dist_c[0] = root_c[RB][MW-1:0];
	assign r_c[0]    = pl_c[RB][NUM_AXES*MW-1:0];
	assign q_c[0]    = '0;
	assign sg_c[0]   = pl_c[RB][PW-1 -: NUM_AXES];

	for (genvar j = 0; j < QW; j++) begin : g_div
		dvu_div_cell #(.DW(MW), .QW(QW), .FIRST(j == 0)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl_i  ('{en: en, vld: dv[j]}),
			.dist_i (dist_c[j]),
			.r_i    (r_c[j]),
			.q_i    (q_c[j]),
			.sgn_i  (sg_c[j]),
			.vld_o  (dv[j+1]),
			.dist_o (dist_c[j+1]),
			.r_o    (r_c[j+1]),
			.q_o    (q_c[j+1]),
			.sgn_o  (sg_c[j+1])
		);
	end

	logic [NUM_AXES-1:0][UW-1:0] unit_v;

	assign out_valid   = dv[QW];
	assign en          = !out_valid || out_ready;
	assign in_ready    = en;
	assign zero_length = dist_c[QW] == '0;
	assign span_length = dist_c[QW];

	always_comb begin
		for (int k = 0; k < NUM_AXES; k++) begin
			if (zero_length) begin
				unit_v[k] = '0;
			end else if (sg_c[QW][k]) begin
				unit_v[k] = UW'(-{1'b0, q_c[QW][k]});
			end else begin
				unit_v[k] = {1'b0, q_c[QW][k]};
			end
		end
	end

	assign unit_x = unit_v[0];
	assign unit_y = unit_v[1];
	assign unit_z = unit_v[2];

`ifndef SYNTHESIS
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input accepted while output stalled");
	a_zero_span: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_length |-> span_length == '0 && unit_x == '0 && unit_y == '0
			&& unit_z == '0)
		else $error("coincident points give nonzero result");
	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $signed(unit_x) <= $signed({2'b01, {UNIT_FRAC_BITS{1'b0}}})
			&& $signed(unit_x) >= -$signed({2'b01, {UNIT_FRAC_BITS{1'b0}}}))
		else $error("unit component out of range");
`endif

endmodule

// File: sim/direction_unit_vector_checker.sv
// Checker for the direction unit vector block: watches both channels, predicts each result.
// Depends on the port widths of direction_unit_vector; hands a failure count to the testbench top.
module direction_unit_vector_checker #(
	parameter int unsigned COORD_BITS     = 24,
	parameter int unsigned UNIT_FRAC_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_ready,
	input  logic signed [COORD_BITS-1:0]     start_x,
	input  logic signed [COORD_BITS-1:0]     start_y,
	input  logic signed [COORD_BITS-1:0]     start_z,
	input  logic signed [COORD_BITS-1:0]     end_x,
	input  logic signed [COORD_BITS-1:0]     end_y,
	input  logic signed [COORD_BITS-1:0]     end_z,
	input  logic                             out_valid,
	input  logic                             out_ready,
	input  logic signed [UNIT_FRAC_BITS+1:0] unit_x,
	input  logic signed [UNIT_FRAC_BITS+1:0] unit_y,
	input  logic signed [UNIT_FRAC_BITS+1:0] unit_z,
	input  logic [COORD_BITS:0]              span_length,
	input  logic                             zero_length,
	output int                               errors,
	output int                               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [UNIT_FRAC_BITS+1:0] ux;
		logic [UNIT_FRAC_BITS+1:0] uy;
		logic [UNIT_FRAC_BITS+1:0] uz;
		logic [COORD_BITS:0]       span;
		logic                      coincident;
	} direction_t;

	direction_t expected_dirs[$];

	function automatic logic [63:0] floor_root(logic [127:0] v);
		logic [63:0] root;
		logic [127:0] trial;
		root = '0;
		for (int b = 63; b >= 0; b--) begin
			trial = {64'd0, root | (64'd1 << b)};
			if (trial * trial <= v)
				root = root | (64'd1 << b);
		end
		return root;
	endfunction

	function automatic logic [UNIT_FRAC_BITS+1:0] component(longint d, logic [63:0] span_len);
		logic [63:0] mag, q;
		mag = d < 0 ? -d : d;
		q = (mag << UNIT_FRAC_BITS) / span_len;
		if (q > (64'd1 << UNIT_FRAC_BITS))
			q = 64'd1 << UNIT_FRAC_BITS;
		if (d < 0)
			q = -q;
		return q[UNIT_FRAC_BITS+1:0];
	endfunction

	function automatic direction_t normalize(longint sx, longint sy, longint sz,
			longint ex, longint ey, longint ez);
		direction_t r;
		longint dx, dy, dz;
		logic [127:0] sum;
		logic [63:0] span_len;
		dx = ex - sx;
		dy = ey - sy;
		dz = ez - sz;
		sum = 128'(dx * dx) + 128'(dy * dy) + 128'(dz * dz);
		span_len = floor_root(sum);
		r = '0;
		if (span_len == 0) begin
			r.coincident = 1'b1;
		end else begin
			r.ux = component(dx, span_len);
			r.uy = component(dy, span_len);
			r.uz = component(dz, span_len);
			r.span = span_len[COORD_BITS:0];
		end
		return r;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t: %s is %0h, predicted %0h", $realtime, what, got, want);
		errors++;
	endtask

	initial begin
		errors = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		direction_t want;
		if (arst_n) begin
			if (in_valid && in_ready)
				expected_dirs.insert(expected_dirs.size(), normalize(start_x, start_y,
					start_z, end_x, end_y, end_z));
			if (out_valid && out_ready) begin
				if (expected_dirs.size() == 0) begin
					report("unexpected transfer", 0, 0);
				end else begin
					want = expected_dirs.pop_front();
					if (unit_x !== want.ux) report("unit_x", unit_x, want.ux);
					if (unit_y !== want.uy) report("unit_y", unit_y, want.uy);
					if (unit_z !== want.uz) report("unit_z", unit_z, want.uz);
					if (span_length !== want.span)
						report("span_length", span_length, want.span);
					if (zero_length !== want.coincident)
						report("zero_length", zero_length, want.coincident);
				end
			end
			pending <= expected_dirs.size();
		end
	end
endmodule

// File: sim/direction_unit_vector_tb.sv
// Testbench top for the direction unit vector block: clock, reset, stimulus and verdict.
// Depends on direction_unit_vector and direction_unit_vector_checker.
module direction_unit_vector_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB = 24;
	localparam int UF = 16;
	localparam int LATENCY = CB + UF + 6;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [CB-1:0] start_x = '0, start_y = '0, start_z = '0;
	logic signed [CB-1:0] end_x = '0, end_y = '0, end_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [UF+1:0] unit_x, unit_y, unit_z;
	logic [CB:0] span_length;
	logic zero_length;
	int errors, pending;
	int send_idle = 0, recv_stall = 0;
	bit hold_off = 1'b0;

	always #5 clk = ~clk;

	direction_unit_vector #(.COORD_BITS(CB), .UNIT_FRAC_BITS(UF)) dut (.*);

	direction_unit_vector_checker #(.COORD_BITS(CB), .UNIT_FRAC_BITS(UF)) chk (.*);

	function automatic logic [CB-1:0] coord_value();
		case ($urandom_range(0, 5))
			0: return {1'b1, {(CB-1){1'b0}}};
			1: return {1'b0, {(CB-1){1'b1}}};
			2: return CB'($urandom_range(0, 15)) - CB'(8);
			default: return CB'($urandom);
		endcase
	endfunction

	task automatic offer(logic [CB-1:0] sx, sy, sz, ex, ey, ez);
		while (send_idle != 0 && $urandom_range(1, 100) <= send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		start_x <= sx; start_y <= sy; start_z <= sz;
		end_x <= ex; end_y <= ey; end_z <= ez;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic offer_random();
		logic [CB-1:0] sx, sy, sz;
		sx = coord_value(); sy = coord_value(); sz = coord_value();
		case ($urandom_range(0, 3))
			0: offer(sx, sy, sz, sx + CB'($urandom_range(0, 2)) - CB'(1),
				sy + CB'($urandom_range(0, 2)) - CB'(1), sz);
			1: offer(sx, sy, sz, sx, sy, sz);
			default: offer(sx, sy, sz, coord_value(), coord_value(), coord_value());
		endcase
	endtask

	always @(posedge clk) begin
		out_ready <= !hold_off && (recv_stall == 0 || $urandom_range(1, 100) > recv_stall);
	end

	initial begin
		logic [CB-1:0] mx, mn;
		mx = {1'b0, {(CB-1){1'b1}}};
		mn = {1'b1, {(CB-1){1'b0}}};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		offer(0, 0, 0, 0, 0, 0);
		offer(mx, mx, mx, mx, mx, mx);
		offer(mn, mn, mn, mx, mx, mx);
		offer(mx, mx, mx, mn, mn, mn);
		offer(mn, 0, 0, mx, 0, 0);
		offer(0, mn, 0, 0, mx, 0);
		offer(0, 0, mx, 0, 0, mn);
		offer(0, 0, 0, 1, 0, 0);
		offer(0, 0, 0, -1, 0, 0);
		offer(0, 0, 0, 1, 1, 0);
		offer(0, 0, 0, -1, 1, -1);
		offer(5, 5, 5, 6, 6, 6);
		offer(0, 0, 0, 3, 4, 0);
		offer(-24'sd1, -24'sd1, -24'sd1, 0, 0, 0);
		offer(24'h555555, 24'haaaaaa, 24'h0f0f0f, 24'haaaaaa, 24'h555555, 24'hf0f0f0);
		for (int ph = 0; ph < 4; ph++) begin
			send_idle = (ph == 1 || ph == 3) ? (ph == 1 ? 45 : 36) : 0;
			recv_stall = (ph == 2 || ph == 3) ? (ph == 2 ? 45 : 36) : 0;
			for (int i = 0; i < 140; i++)
				offer_random();
			if (ph == 0) begin
				hold_off = 1'b1;
				fork
					begin
						repeat (200) @(posedge clk);
						hold_off = 1'b0;
					end
					for (int i = 0; i < 80; i++)
						offer_random();
				join
				in_valid <= 1'b0;
				while (pending != 0)
					@(posedge clk);
			end
		end
		in_valid <= 1'b0;
		send_idle = 0;
		recv_stall = 0;
		while (pending != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#5ms;
		$display("Mismatches found");
		$finish;
	end
endmodule
